FILE: sv/rfc_pkg.sv
`default_nettype none

package rfc_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned NumChan  = 4;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned LenW     = 16;
  localparam int unsigned ProdW    = ChanW + LenW;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ChanW-1:0] NormalReset   = 8'd255;
  localparam logic [LenW-1:0]  DurationReset = 16'd500;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NORMAL_RED   = 3'd0,
    CFG_NORMAL_GREEN = 3'd1,
    CFG_NORMAL_BLUE  = 3'd2,
    CFG_NORMAL_ALPHA = 3'd3,
    CFG_FADE_DUR     = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PEND = 2'd1,
    PH_FADE = 2'd2
  } fade_phase_e;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } fade_op_e;

  typedef struct packed {
    logic             op;
    logic [TimeW-1:0] now;
  } in_item_t;

  typedef struct packed {
    logic             visible;
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic [ChanW-1:0] out_alpha;
    logic [1:0]       phase;
    logic             direction;
  } out_item_t;

  // Request to the shared interpolation unit.
  typedef struct packed {
    logic             start;
    logic [ChanW-1:0] from_val;
    logic [ChanW-1:0] to_val;
    logic [LenW-1:0]  elapsed;
    logic [LenW-1:0]  length;
  } lerp_req_t;

  typedef struct packed {
    logic             done;
    logic [ChanW-1:0] value;
  } lerp_rsp_t;

endpackage

`default_nettype wire

FILE: sv/rfc_lerp.sv
`default_nettype none

module rfc_lerp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rfc_pkg::lerp_req_t req_i,
  output rfc_pkg::lerp_rsp_t      rsp_o
);
  import rfc_pkg::*;

  typedef enum logic [1:0] {
    L_IDLE = 2'b01,
    L_DIV  = 2'b10
  } lerp_state_e;

  lerp_state_e      state_q, state_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [LenW-1:0]  rem_q, rem_d;
  logic [ChanW-1:0] quo_q, quo_d;
  logic [ChanW-1:0] base_q, base_d;
  logic             up_q, up_d;
  logic [LenW-1:0]  len_q, len_d;
  logic             done_q, done_d;

  logic             up;
  logic [ChanW-1:0] diff;
  logic [ProdW-1:0] prod;
  logic [LenW:0]    trial;
  logic             ge;

  assign up    = req_i.to_val >= req_i.from_val;
  assign diff  = up ? (req_i.to_val - req_i.from_val) : (req_i.from_val - req_i.to_val);
  assign prod  = {{LenW{1'b0}}, diff} * {{ChanW{1'b0}}, req_i.elapsed};

  // Restoring division: the quotient never exceeds the difference, so the
  // high product bits already sit below the divisor and eight steps suffice.
  // The low product bits shift out of quo_q as quotient bits shift in.
  assign trial = {rem_q, quo_q[ChanW-1]};
  assign ge    = (len_q != '0) && (trial >= {1'b0, len_q});

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    base_d  = base_q;
    up_d    = up_q;
    len_d   = len_q;
    done_d  = 1'b0;
    case (state_q)
      L_IDLE: begin
        if (req_i.start) begin
          rem_d   = prod[ProdW-1:ChanW];
          quo_d   = prod[ChanW-1:0];
          base_d  = req_i.from_val;
          up_d    = up;
          len_d   = req_i.length;
          cnt_d   = '0;
          state_d = L_DIV;
        end
      end
      L_DIV: begin
        rem_d = ge ? LenW'(trial - {1'b0, len_q}) : trial[LenW-1:0];
        quo_d = {quo_q[ChanW-2:0], ge};
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          done_d  = 1'b1;
          state_d = L_IDLE;
        end
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    base_q <= base_d;
    up_q   <= up_d;
    len_q  <= len_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = up_q ? (base_q + quo_q) : (base_q - quo_q);

endmodule

`default_nettype wire

FILE: sv/rgba_fade_controller_top.sv
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_ready   rfc_pkg::in_item_t (op, now)
// out      output     out_valid/out_ready rfc_pkg::out_item_t (one beat per input beat)
// cfg      input      cfg_we              cfg_idx, cfg_data (write only)
//
// A start beat, an idle tick, a tick that begins a fade and a tick that ends one
// go from acceptance through T_FIN to the result register. A tick inside a running
// fade first passes each color channel in turn through the single shared
// interpolation unit: a launch state, one multiply with eight restoring divide steps
// and a hand-back state. T_FIN waits while an earlier result is still unaccepted.
// in_ready is low while a beat is in work; a result waiting on out_ready does not
// block the next input beat. Reset is asynchronous and needs no clearing pass.
`default_nettype none

module rgba_fade_controller_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire rfc_pkg::in_item_t               in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output rfc_pkg::out_item_t                   out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [rfc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [rfc_pkg::CfgDataW-1:0]    cfg_data_i
);
  import rfc_pkg::*;

  typedef enum logic [3:0] {
    T_IDLE   = 4'b0001,
    T_LAUNCH = 4'b0010,
    T_WAIT   = 4'b0100,
    T_FIN    = 4'b1000
  } top_state_e;

  top_state_e          state_q, state_d;
  logic [ChanW-1:0]    nred_q, ngreen_q, nblue_q, nalpha_q;
  logic [LenW-1:0]     dur_q;
  fade_phase_e         phase_q, phase_d;
  logic                dir_q, dir_d;
  logic                shown_q, shown_d;
  logic [TimeW-1:0]    begin_q, begin_d;
  logic [LenW-1:0]     len_q, len_d;
  logic [31:0]         from_q, from_d;
  logic [31:0]         to_q, to_d;
  logic [31:0]         cur_q, cur_d;
  logic [1:0]          chan_q, chan_d;
  logic [LenW-1:0]     elapsed_q, elapsed_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;

  logic                in_fire;
  logic [TimeW-1:0]    elapsed_full;
  logic                expired;
  logic [23:0]         rgb;
  lerp_req_t           lerp_req;
  lerp_rsp_t           lerp_rsp;

  assign in_ready_o   = (state_q == T_IDLE);
  assign in_fire      = in_valid_i && in_ready_o;
  assign elapsed_full = in_data_i.now - begin_q;
  assign expired      = elapsed_full > {{(TimeW-LenW){1'b0}}, len_q};
  assign rgb          = {nblue_q, ngreen_q, nred_q};

  assign lerp_req.start    = (state_q == T_LAUNCH);
  assign lerp_req.from_val = from_q[{chan_q, 3'b000} +: ChanW];
  assign lerp_req.to_val   = to_q[{chan_q, 3'b000} +: ChanW];
  assign lerp_req.elapsed  = elapsed_q;
  assign lerp_req.length   = len_q;

  rfc_lerp u_lerp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lerp_req),
    .rsp_o  (lerp_rsp)
  );

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    dir_d       = dir_q;
    shown_d     = shown_q;
    begin_d     = begin_q;
    len_d       = len_q;
    from_d      = from_q;
    to_d        = to_q;
    cur_d       = cur_q;
    chan_d      = chan_q;
    elapsed_d   = elapsed_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (state_q)
      T_IDLE: begin
        if (in_fire) begin
          state_d = T_FIN;
          if (in_data_i.op == OP_START) begin
            phase_d = PH_PEND;
          end else if (phase_q == PH_PEND) begin
            // Starting tick: elapsed is zero, so the colour equals the start point.
            phase_d = PH_FADE;
            begin_d = in_data_i.now;
            len_d   = dur_q;
            shown_d = 1'b1;
            if (!dir_q) begin
              from_d = {8'h00, rgb};
              to_d   = {nalpha_q, rgb};
              cur_d  = {8'h00, rgb};
            end else begin
              from_d = cur_q;
              to_d   = {8'h00, cur_q[23:0]};
            end
          end else if (phase_q == PH_FADE) begin
            if (expired) begin
              phase_d = PH_IDLE;
              dir_d   = !dir_q;
              shown_d = !dir_q;
              cur_d   = to_q;
            end else begin
              elapsed_d = elapsed_full[LenW-1:0];
              chan_d    = '0;
              state_d   = T_LAUNCH;
            end
          end
        end
      end
      T_LAUNCH: state_d = T_WAIT;
      T_WAIT: begin
        if (lerp_rsp.done) begin
          cur_d[{chan_q, 3'b000} +: ChanW] = lerp_rsp.value;
          if (chan_q == 2'(NumChan - 1)) begin
            state_d = T_FIN;
          end else begin
            chan_d  = chan_q + 2'd1;
            state_d = T_LAUNCH;
          end
        end
      end
      T_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.visible     = shown_q;
          out_d.out_red     = cur_q[7:0];
          out_d.out_green   = cur_q[15:8];
          out_d.out_blue    = cur_q[23:16];
          out_d.out_alpha   = cur_q[31:24];
          out_d.phase       = phase_q;
          out_d.direction   = dir_q;
          state_d           = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      phase_q     <= PH_IDLE;
      dir_q       <= 1'b0;
      shown_q     <= 1'b0;
      begin_q     <= '0;
      len_q       <= '0;
      from_q      <= '0;
      to_q        <= '0;
      cur_q       <= '0;
      chan_q      <= '0;
      out_valid_q <= 1'b0;
      nred_q      <= NormalReset;
      ngreen_q    <= NormalReset;
      nblue_q     <= NormalReset;
      nalpha_q    <= NormalReset;
      dur_q       <= DurationReset;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      dir_q       <= dir_d;
      shown_q     <= shown_d;
      begin_q     <= begin_d;
      len_q       <= len_d;
      from_q      <= from_d;
      to_q        <= to_d;
      cur_q       <= cur_d;
      chan_q      <= chan_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NORMAL_RED:   nred_q   <= cfg_data_i[ChanW-1:0];
          CFG_NORMAL_GREEN: ngreen_q <= cfg_data_i[ChanW-1:0];
          CFG_NORMAL_BLUE:  nblue_q  <= cfg_data_i[ChanW-1:0];
          CFG_NORMAL_ALPHA: nalpha_q <= cfg_data_i[ChanW-1:0];
          CFG_FADE_DUR:     dur_q    <= cfg_data_i[LenW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    elapsed_q <= elapsed_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: sv/rfc_checker.sv
`default_nettype none

module rfc_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire rfc_pkg::out_item_t out_data_o
);
  import rfc_pkg::*;

  // A stalled result beat stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // An accepted beat keeps the input closed for at least the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input reopened right after a beat");

  // The unused phase code never shows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.phase == PH_IDLE || out_data_o.phase == PH_PEND ||
                     out_data_o.phase == PH_FADE))
    else $error("illegal phase reported");

  // A running fade always has the output shown.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.phase == PH_FADE) |-> out_data_o.visible)
    else $error("fading while hidden");

endmodule

bind rgba_fade_controller_top rfc_checker u_rfc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

FILE: bench/tb_rgba_fade_controller_top.sv
module tb_rgba_fade_controller_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rfc_pkg::*;

  localparam int unsigned LongHold     = 600;
  localparam int unsigned QuietLimit   = 4000;
  localparam int unsigned RandomPhases = 14;
  localparam int unsigned PhaseBeats   = 150;
  localparam logic [CfgIdxW-1:0] CfgIdxTop = '1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  always #10 clk_i = ~clk_i;

  rgba_fade_controller_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Shadow copy of the fader: register file and state.
  logic [7:0] nrm_r = NormalReset;
  logic [7:0] nrm_g = NormalReset;
  logic [7:0] nrm_b = NormalReset;
  logic [7:0] nrm_a = NormalReset;
  logic [15:0] dur = DurationReset;
  fade_phase_e ph = PH_IDLE;
  logic dir = 1'b0;
  logic shown_q = 1'b0;
  logic [31:0] t_begin = '0;
  logic [15:0] len_q = '0;
  logic [31:0] from_c = '0;
  logic [31:0] to_c = '0;
  logic [31:0] cur_c = '0;

  in_item_t pending_beats[$];
  out_item_t expected_frames[$];

  int unsigned beats_queued = 0;
  int unsigned beats_in = 0;
  int unsigned frames_checked = 0;
  int unsigned mismatches = 0;
  int unsigned fade_ins_done = 0;
  int unsigned fade_outs_done = 0;
  int unsigned fades_abandoned = 0;
  int unsigned settings_used = 0;
  int unsigned send_level = 1;
  int unsigned recv_level = 1;
  int unsigned stall_requests = 0;
  int unsigned stall_served = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_cnt = 0;
  int unsigned quiet_cycles = 0;

  function automatic int unsigned pick_gap(input int unsigned level);
    int unsigned r;
    if (level == 0) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(20, 4);
    return $urandom_range(150, 30);
  endfunction

  function automatic logic [7:0] blend_channel(input logic [7:0] f, input logic [7:0] t,
                                               input logic [31:0] e, input logic [15:0] len);
    logic [31:0] d;
    if (len == 0) return f;
    if (t >= f) begin
      d = 32'(t - f);
      return 8'(f + (d * e) / len);
    end
    d = 32'(f - t);
    return 8'(f - (d * e) / len);
  endfunction

  function automatic logic [31:0] blend_color(input logic [31:0] f, input logic [31:0] t,
                                              input logic [31:0] e, input logic [15:0] len);
    logic [31:0] res;
    res = '0;
    for (int k = 0; k < NumChan; k++) begin
      res[8*k +: 8] = blend_channel(f[8*k +: 8], t[8*k +: 8], e, len);
    end
    return res;
  endfunction

  // Advances the shadow fader by one accepted beat and records the frame it must produce.
  task automatic advance_fader(input in_item_t b);
    logic [31:0] span;
    out_item_t f;
    if (b.op == OP_START) begin
      if (ph == PH_FADE) fades_abandoned++;
      ph = PH_PEND;
    end else if (ph == PH_PEND) begin
      ph = PH_FADE;
      t_begin = b.now;
      len_q = dur;
      shown_q = 1'b1;
      if (dir == 1'b0) begin
        from_c = {8'h00, nrm_b, nrm_g, nrm_r};
        to_c = {nrm_a, nrm_b, nrm_g, nrm_r};
      end else begin
        from_c = cur_c;
        to_c = {8'h00, cur_c[23:0]};
      end
      cur_c = blend_color(from_c, to_c, '0, len_q);
    end else if (ph == PH_FADE) begin
      span = b.now - t_begin;
      if (span > len_q) begin
        ph = PH_IDLE;
        if (dir == 1'b0) fade_ins_done++;
        else fade_outs_done++;
        shown_q = ~dir;
        dir = ~dir;
        cur_c = to_c;
      end else begin
        cur_c = blend_color(from_c, to_c, span, len_q);
      end
    end
    f.visible = shown_q;
    f.out_red = cur_c[7:0];
    f.out_green = cur_c[15:8];
    f.out_blue = cur_c[23:16];
    f.out_alpha = cur_c[31:24];
    f.phase = ph;
    f.direction = dir;
    expected_frames.push_back(f);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 40) begin
      $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
    end
    mismatches++;
  endtask

  task automatic check_frame(input out_item_t got);
    out_item_t want;
    if (expected_frames.size() == 0) begin
      report_mismatch("result beat with nothing expected", got[31:0], '0);
      return;
    end
    want = expected_frames.pop_front();
    if (got.visible !== want.visible)
      report_mismatch("visible", 32'(got.visible), 32'(want.visible));
    if (got.out_red !== want.out_red)
      report_mismatch("out_red", 32'(got.out_red), 32'(want.out_red));
    if (got.out_green !== want.out_green)
      report_mismatch("out_green", 32'(got.out_green), 32'(want.out_green));
    if (got.out_blue !== want.out_blue)
      report_mismatch("out_blue", 32'(got.out_blue), 32'(want.out_blue));
    if (got.out_alpha !== want.out_alpha)
      report_mismatch("out_alpha", 32'(got.out_alpha), 32'(want.out_alpha));
    if (got.phase !== want.phase)
      report_mismatch("phase", 32'(got.phase), 32'(want.phase));
    if (got.direction !== want.direction)
      report_mismatch("direction", 32'(got.direction), 32'(want.direction));
    frames_checked++;
  endtask

  // Input driver: presents queued beats, with random gaps between them.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      send_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        advance_fader(in_data_i);
        beats_in++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          in_data_i <= pending_beats.pop_front();
          in_valid_i <= 1'b1;
          send_gap = pick_gap(send_level);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_gap = 0;
      hold_cnt = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        check_frame(out_data_o);
        recv_gap = pick_gap(recv_level);
      end
      if (stall_served != stall_requests) begin
        stall_served++;
        hold_cnt = LongHold;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Timeout: no beat moved for %0d cycles, %0d results outstanding.",
               QuietLimit, expected_frames.size());
      $display("rgba_fade_controller_top: mismatch");
      $finish;
    end
  end

  task automatic queue_beat(input fade_op_e op, input logic [31:0] stamp);
    in_item_t b;
    b.op = op;
    b.now = stamp;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  // Holds the sender until every queued beat has produced its result.
  task automatic settle();
    while (frames_checked < beats_queued) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_NORMAL_RED:   nrm_r = data[7:0];
      CFG_NORMAL_GREEN: nrm_g = data[7:0];
      CFG_NORMAL_BLUE:  nrm_b = data[7:0];
      CFG_NORMAL_ALPHA: nrm_a = data[7:0];
      CFG_FADE_DUR:     dur = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Upper byte of the color writes carries junk that the block must drop.
  task automatic program_fader(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                               input logic [7:0] a, input logic [15:0] d);
    write_reg(CFG_NORMAL_RED, {8'($urandom), r});
    write_reg(CFG_NORMAL_GREEN, {8'($urandom), g});
    write_reg(CFG_NORMAL_BLUE, {8'($urandom), b});
    write_reg(CFG_NORMAL_ALPHA, {8'($urandom), a});
    write_reg(CFG_FADE_DUR, d);
    write_reg(CfgIdxW'($urandom_range(CfgIdxTop, CFG_FADE_DUR + 1)), 16'($urandom));
    settings_used++;
  endtask

  function automatic logic [7:0] pick_level();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 2) return 8'h00;
    if (r < 4) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 16'd0;
    if (r < 20) return 16'hFFFF;
    if (r < 35) return 16'd1;
    if (r < 80) return 16'($urandom_range(40, 2));
    return 16'($urandom_range(65534, 41));
  endfunction

  // One fade with random timing: start, begin tick, a few ticks inside and, unless it stops early, an end tick.
  task automatic queue_fade();
    logic [31:0] t0;
    logic [31:0] e;
    logic [31:0] len32;
    int unsigned n;
    len32 = {16'h0, dur};
    t0 = $urandom;
    queue_beat(OP_START, $urandom);
    if ($urandom_range(19) == 0) queue_beat(OP_START, $urandom);
    queue_beat(OP_TICK, t0);
    n = $urandom_range(6, 1);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: e = '0;
        1: e = len32;
        default: e = $urandom_range(len32, 0);
      endcase
      queue_beat(OP_TICK, t0 + e);
      // Stopping here leaves the fade open, so a later start can abandon it.
      if ($urandom_range(24) == 0) return;
    end
    case ($urandom_range(2))
      0: e = len32 + 1;
      1: e = len32 + 1 + $urandom_range(5, 0);
      default: begin
        e = $urandom;
        if (e <= len32) e = len32 + 1;
      end
    endcase
    queue_beat(OP_TICK, t0 + e);
  endtask

  task automatic queue_noise();
    int unsigned n;
    n = $urandom_range(4, 1);
    for (int i = 0; i < n; i++) begin
      queue_beat(fade_op_e'($urandom_range(1)), $urandom);
    end
  endtask

  initial begin
    int unsigned mark;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: idle ticks, then a fade-in whose timer wraps through zero.
    queue_beat(OP_TICK, '0);
    queue_beat(OP_TICK, '1);
    queue_beat(OP_START, $urandom);
    queue_beat(OP_TICK, 32'hFFFF_FF00);
    queue_beat(OP_TICK, 32'hFFFF_FF00 + 32'd250);
    queue_beat(OP_TICK, 32'hFFFF_FF00 + 32'd500);
    queue_beat(OP_TICK, 32'hFFFF_FF00 + 32'd501);
    queue_beat(OP_TICK, 32'h0000_1234);
    queue_beat(OP_START, $urandom);
    queue_beat(OP_TICK, 32'h0000_1000);
    queue_beat(OP_START, $urandom);
    queue_beat(OP_TICK, 32'h8000_0000);
    queue_beat(OP_TICK, 32'h7FFF_FFFF);
    settle();

    // Zero length: output holds the start color until elapsed becomes nonzero.
    program_fader(8'h00, 8'hFF, 8'h80, 8'h01, 16'd0);
    queue_beat(OP_START, $urandom);
    queue_beat(OP_TICK, 32'h0000_00AA);
    queue_beat(OP_TICK, 32'h0000_00AA);
    queue_beat(OP_TICK, 32'h0000_00AB);
    queue_beat(OP_START, $urandom);
    queue_beat(OP_START, $urandom);
    queue_beat(OP_TICK, 32'h0000_0010);
    queue_beat(OP_TICK, 32'h0000_0011);
    settle();

    program_fader(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    queue_beat(OP_START, $urandom);
    queue_beat(OP_TICK, 32'd0);
    queue_beat(OP_TICK, 32'd32768);
    queue_beat(OP_TICK, 32'd65535);
    queue_beat(OP_TICK, 32'd65536);
    settle();

    for (int p = 0; p < RandomPhases; p++) begin
      program_fader(pick_level(), pick_level(), pick_level(), pick_level(), pick_length());
      @(negedge clk_i);
      send_level = (p % 4 != 1) ? 1 : 0;
      recv_level = (p % 3 != 2) ? 1 : 0;
      // The receiver stops for a long stretch while the sender keeps offering.
      if (p == 3 || p == 9) stall_requests++;
      mark = beats_queued;
      while (beats_queued - mark < PhaseBeats) begin
        if ($urandom_range(9) < 8) queue_fade();
        else queue_noise();
        if ($urandom_range(3) == 0) queue_beat(OP_TICK, $urandom);
      end
      settle();
    end

    repeat (60) @(posedge clk_i);
    if (expected_frames.size() != 0) begin
      report_mismatch("results never delivered", expected_frames.size(), '0);
    end
    $display("Sent %0d beats and checked %0d results over %0d register settings.",
             beats_in, frames_checked, settings_used);
    $display("Finished %0d fade-ins and %0d fade-outs; %0d fades were cut short by a start.",
             fade_ins_done, fade_outs_done, fades_abandoned);
    if (mismatches == 0) begin
      $display("rgba_fade_controller_top: match");
    end else begin
      $display("rgba_fade_controller_top: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/rfc_pkg.sv
sv/rfc_lerp.sv
sv/rgba_fade_controller_top.sv
sv/rfc_checker.sv
bench/tb_rgba_fade_controller_top.sv
